>>> rtl/multi_module_heartbeat_watchdog_macros.svh
// ---------------------------------------------------------------------------
// Heartbeat watchdog assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ---------------------------------------------------------------------------
`ifndef MULTI_MODULE_HEARTBEAT_WATCHDOG_MACROS_SVH
`define MULTI_MODULE_HEARTBEAT_WATCHDOG_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define HBW_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("heartbeat watchdog check failed");

// Consequent checked in the cycle after the antecedent
`define HBW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("heartbeat watchdog check failed");

`endif

>>> rtl/hbw_pkg.sv
// ---------------------------------------------------------------------------
// Heartbeat watchdog package
// Sizes, reset values, codes and the controller/datapath interface types.
// ---------------------------------------------------------------------------
package hbw_pkg;

  localparam int NumModules = 16;
  localparam int CountW     = 16;
  localparam int IdxW       = 4;
  localparam int TimeoutW   = 16;
  localparam int HostIdW    = 4;
  localparam int AddrW      = 4;
  localparam int DataW      = 32;

  localparam logic [CountW-1:0]   CountMax          = {CountW{1'b1}};
  localparam logic [TimeoutW-1:0] DefaultTimeoutRst = 16'd500;
  localparam logic [TimeoutW-1:0] HostTimeoutRst    = 16'd2000;
  localparam logic [HostIdW-1:0]  HostModuleRst     = 4'd15;

  // Input operation codes
  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_BEAT = 2'd1,
    OP_SCAN = 2'd2
  } op_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_DEFAULT_TIMEOUT = 2'd0,
    REG_HOST_TIMEOUT    = 2'd1,
    REG_HOST_MODULE     = 2'd2
  } reg_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_LOAD,
    ST_SEEK,
    ST_WAIT
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic tick;
    logic beat;
    logic scan_start;
    logic calc_step;
    logic load_pend;
    logic idx_inc;
    logic emit;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic idx_last;
    logic pend_empty;
    logic pend_hit;
  } sts_t;

endpackage

>>> rtl/multi_module_heartbeat_watchdog.sv
// ---------------------------------------------------------------------------
// Multi-module heartbeat watchdog
// Tracks elapsed time per module and reports online/offline changes on scan.
// ---------------------------------------------------------------------------
// Channel   Handshake                     Payload
// in        in_valid_i / in_ready_o       op_i, module_id_i
// out       out_valid_o / out_ready_i     changed_module_o, is_offline_o,
//                                         offline_mask_o, last_o
// cfg       psel, penable, pwrite, pready paddr, pwdata, prdata
//
// Tick and heartbeat finish in the accepting state. A scan passes through
// its accepting state, serial timeout compares over all 16 modules, forming
// the change list, a walk over the modules with one result per changed
// module, and a closing step; it runs longer while a result waits. The shared
// counter compare and the result register set this.
// No clearing pass: the block takes items from the first cycle after reset.
// ---------------------------------------------------------------------------
module multi_module_heartbeat_watchdog (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     op_i,
  input  logic [hbw_pkg::IdxW-1:0]       module_id_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [hbw_pkg::IdxW-1:0]       changed_module_o,
  output logic                           is_offline_o,
  output logic [hbw_pkg::NumModules-1:0] offline_mask_o,
  output logic                           last_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hbw_pkg::AddrW-1:0]      paddr,
  input  logic [hbw_pkg::DataW-1:0]      pwdata,
  output logic [hbw_pkg::DataW-1:0]      prdata,
  output logic                           pready
);

  hbw_pkg::cmd_t                cmd;
  hbw_pkg::sts_t                sts;
  logic [hbw_pkg::TimeoutW-1:0] default_timeout;
  logic [hbw_pkg::TimeoutW-1:0] host_timeout;
  logic [hbw_pkg::HostIdW-1:0]  host_module;

  hbw_cfg u_cfg (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .default_timeout_o (default_timeout),
    .host_timeout_o    (host_timeout),
    .host_module_o     (host_module)
  );

  hbw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  hbw_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .module_id_i       (module_id_i),
    .default_timeout_i (default_timeout),
    .host_timeout_i    (host_timeout),
    .host_module_i     (host_module),
    .sts_o             (sts),
    .changed_module_o  (changed_module_o),
    .is_offline_o      (is_offline_o),
    .offline_mask_o    (offline_mask_o),
    .last_o            (last_o)
  );

endmodule

>>> rtl/hbw_cfg.sv
// ---------------------------------------------------------------------------
// Heartbeat watchdog configuration registers
// APB-style register file holding the timeouts and the host module index.
// ---------------------------------------------------------------------------
module hbw_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hbw_pkg::AddrW-1:0]      paddr,
  input  logic [hbw_pkg::DataW-1:0]      pwdata,
  output logic [hbw_pkg::DataW-1:0]      prdata,
  output logic                           pready,
  output logic [hbw_pkg::TimeoutW-1:0]   default_timeout_o,
  output logic [hbw_pkg::TimeoutW-1:0]   host_timeout_o,
  output logic [hbw_pkg::HostIdW-1:0]    host_module_o
);

  logic [hbw_pkg::TimeoutW-1:0] def_to_q, def_to_d;
  logic [hbw_pkg::TimeoutW-1:0] host_to_q, host_to_d;
  logic [hbw_pkg::HostIdW-1:0]  host_id_q, host_id_d;
  logic                         wr_en;
  hbw_pkg::reg_e                reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = hbw_pkg::reg_e'(paddr[3:2]);

  // Decode the write transfer
  always_comb begin
    def_to_d  = def_to_q;
    host_to_d = host_to_q;
    host_id_d = host_id_q;
    if (wr_en) begin
      unique case (reg_idx)
        hbw_pkg::REG_DEFAULT_TIMEOUT: def_to_d  = pwdata[hbw_pkg::TimeoutW-1:0];
        hbw_pkg::REG_HOST_TIMEOUT:    host_to_d = pwdata[hbw_pkg::TimeoutW-1:0];
        hbw_pkg::REG_HOST_MODULE:     host_id_d = pwdata[hbw_pkg::HostIdW-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      hbw_pkg::REG_DEFAULT_TIMEOUT:
        prdata = hbw_pkg::DataW'(def_to_q);
      hbw_pkg::REG_HOST_TIMEOUT:
        prdata = hbw_pkg::DataW'(host_to_q);
      hbw_pkg::REG_HOST_MODULE:
        prdata = hbw_pkg::DataW'(host_id_q);
      default:
        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_to_q  <= hbw_pkg::DefaultTimeoutRst;
      host_to_q <= hbw_pkg::HostTimeoutRst;
      host_id_q <= hbw_pkg::HostModuleRst;
    end else begin
      def_to_q  <= def_to_d;
      host_to_q <= host_to_d;
      host_id_q <= host_id_d;
    end
  end

  assign default_timeout_o = def_to_q;
  assign host_timeout_o    = host_to_q;
  assign host_module_o     = host_id_q;

endmodule

>>> rtl/hbw_dp.sv
// ---------------------------------------------------------------------------
// Heartbeat watchdog datapath
// Elapsed counters, serial timeout compare, change list and result register.
// ---------------------------------------------------------------------------
`include "multi_module_heartbeat_watchdog_macros.svh"

module hbw_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  hbw_pkg::cmd_t                  cmd_i,
  input  logic [hbw_pkg::IdxW-1:0]       module_id_i,
  input  logic [hbw_pkg::TimeoutW-1:0]   default_timeout_i,
  input  logic [hbw_pkg::TimeoutW-1:0]   host_timeout_i,
  input  logic [hbw_pkg::HostIdW-1:0]    host_module_i,
  output hbw_pkg::sts_t                  sts_o,
  output logic [hbw_pkg::IdxW-1:0]       changed_module_o,
  output logic                           is_offline_o,
  output logic [hbw_pkg::NumModules-1:0] offline_mask_o,
  output logic                           last_o
);

  logic [hbw_pkg::CountW-1:0]     cnt_q [hbw_pkg::NumModules];
  logic [hbw_pkg::CountW-1:0]     cnt_d [hbw_pkg::NumModules];
  logic [hbw_pkg::NumModules-1:0] mask_q, mask_d;
  logic [hbw_pkg::NumModules-1:0] rep_q, rep_d;
  logic [hbw_pkg::NumModules-1:0] pend_q, pend_d;
  logic [hbw_pkg::IdxW-1:0]       idx_q, idx_d;
  logic [hbw_pkg::IdxW-1:0]       out_mod_q, out_mod_d;
  logic                           out_off_q, out_off_d;
  logic [hbw_pkg::NumModules-1:0] out_mask_q, out_mask_d;
  logic                           out_last_q, out_last_d;

  logic [hbw_pkg::TimeoutW-1:0]   limit;
  logic                           over;
  logic [hbw_pkg::NumModules-1:0] idx_bit;
  logic [hbw_pkg::NumModules-1:0] pend_rest;
  logic                           beat_ok;

  // Compare the selected counter against its timeout
  assign limit     = (host_module_i == idx_q) ? host_timeout_i : default_timeout_i;
  assign over      = cnt_q[idx_q] > limit;
  assign idx_bit   = hbw_pkg::NumModules'(1) << idx_q;
  assign pend_rest = pend_q & ~idx_bit;
  assign beat_ok   = ({1'b0, module_id_i} < (hbw_pkg::IdxW + 1)'(hbw_pkg::NumModules));

  always_comb begin
    cnt_d      = cnt_q;
    mask_d     = mask_q;
    rep_d      = rep_q;
    pend_d     = pend_q;
    idx_d      = idx_q;
    out_mod_d  = out_mod_q;
    out_off_d  = out_off_q;
    out_mask_d = out_mask_q;
    out_last_d = out_last_q;

    // Advance every counter, saturating
    if (cmd_i.tick) begin
      for (int i = 0; i < hbw_pkg::NumModules; i++) begin
        if (cnt_q[i] != hbw_pkg::CountMax) begin
          cnt_d[i] = cnt_q[i] + hbw_pkg::CountW'(1);
        end
      end
    end

    // Clear the counter of the module that beat
    if (cmd_i.beat && beat_ok) begin
      cnt_d[module_id_i] = '0;
    end

    // Start a fresh mask
    if (cmd_i.scan_start) begin
      idx_d  = '0;
      mask_d = '0;
    end

    // One module per cycle into the mask
    if (cmd_i.calc_step) begin
      mask_d[idx_q] = over;
      idx_d         = idx_q + hbw_pkg::IdxW'(1);
    end

    // Build the change list
    if (cmd_i.load_pend) begin
      pend_d = mask_q ^ rep_q;
      idx_d  = '0;
    end

    if (cmd_i.idx_inc) begin
      idx_d = idx_q + hbw_pkg::IdxW'(1);
    end

    // Load one result and fold the change into the reported mask
    if (cmd_i.emit) begin
      out_mod_d     = idx_q;
      out_off_d     = mask_q[idx_q];
      out_mask_d    = mask_q;
      out_last_d    = (pend_rest == '0);
      pend_d        = pend_rest;
      rep_d[idx_q]  = mask_q[idx_q];
      idx_d         = idx_q + hbw_pkg::IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < hbw_pkg::NumModules; i++) begin
        cnt_q[i] <= '0;
      end
      rep_q  <= '0;
      mask_q <= '0;
      pend_q <= '0;
      idx_q  <= '0;
    end else begin
      cnt_q  <= cnt_d;
      rep_q  <= rep_d;
      mask_q <= mask_d;
      pend_q <= pend_d;
      idx_q  <= idx_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    out_mod_q  <= out_mod_d;
    out_off_q  <= out_off_d;
    out_mask_q <= out_mask_d;
    out_last_q <= out_last_d;
  end

  assign sts_o.idx_last   = (idx_q == hbw_pkg::IdxW'(hbw_pkg::NumModules - 1));
  assign sts_o.pend_empty = (pend_q == '0);
  assign sts_o.pend_hit   = pend_q[idx_q];

  assign changed_module_o = out_mod_q;
  assign is_offline_o     = out_off_q;
  assign offline_mask_o   = out_mask_q;
  assign last_o           = out_last_q;

  // A reported change leaves the pending list
  `HBW_ASSERT_NEXT(a_emit_clears, cmd_i.emit, !pend_q[$past(idx_q)])
  // The last flag marks an emptied change list
  `HBW_ASSERT_NEXT(a_last_empty, cmd_i.emit, out_last_q == (pend_q == '0))
  // Only changed modules are reported
  `HBW_ASSERT_SAME(a_emit_hit, cmd_i.emit, pend_q[idx_q] && (mask_q[idx_q] != rep_q[idx_q]))

endmodule

>>> rtl/hbw_ctrl.sv
// ---------------------------------------------------------------------------
// Heartbeat watchdog controller
// Sequences tick, heartbeat and scan items and the result handshake.
// ---------------------------------------------------------------------------
module hbw_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    op_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  hbw_pkg::sts_t sts_i,
  output hbw_pkg::cmd_t cmd_o
);

  hbw_pkg::state_e state_q, state_d;
  hbw_pkg::op_e    op;

  assign op = hbw_pkg::op_e'(op_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hbw_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      // Take an item and dispatch it
      hbw_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (op)
            hbw_pkg::OP_TICK: cmd_o.tick = 1'b1;
            hbw_pkg::OP_BEAT: cmd_o.beat = 1'b1;
            hbw_pkg::OP_SCAN: begin
              cmd_o.scan_start = 1'b1;
              state_d          = hbw_pkg::ST_CALC;
            end
            default: ;
          endcase
        end
      end
      // Compare one module a cycle
      hbw_pkg::ST_CALC: begin
        cmd_o.calc_step = 1'b1;
        if (sts_i.idx_last) begin
          state_d = hbw_pkg::ST_LOAD;
        end
      end
      hbw_pkg::ST_LOAD: begin
        cmd_o.load_pend = 1'b1;
        state_d         = hbw_pkg::ST_SEEK;
      end
      // Walk to the next changed module
      hbw_pkg::ST_SEEK: begin
        if (sts_i.pend_empty) begin
          state_d = hbw_pkg::ST_IDLE;
        end else if (sts_i.pend_hit) begin
          cmd_o.emit = 1'b1;
          state_d    = hbw_pkg::ST_WAIT;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      // Hold the result until transferred
      hbw_pkg::ST_WAIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = hbw_pkg::ST_SEEK;
        end
      end
      default: state_d = hbw_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> tb/sv/multi_module_heartbeat_watchdog_tb.sv
// ---------------------------------------------------------------------------
// Heartbeat watchdog testbench
// Drives tick, heartbeat, scan and unused items through the input channel,
// sets the timeouts over the register port between phases, and checks every
// change transfer against a cycle-free model of the counters and the mask.
// ---------------------------------------------------------------------------
module multi_module_heartbeat_watchdog_tb;

  import hbw_pkg::*;

  localparam logic [1:0] OpUnused     = 2'd3;
  localparam int         StallLimit   = 4000;
  localparam int         SettleCycles = 64;
  localparam int         RandPhases   = 6;
  localparam int         PhaseItems   = 48;
  localparam int         BurstTicks   = 8;

  // One change transfer as the block reports it
  typedef struct packed {
    logic [IdxW-1:0]       idx;
    logic                  offline;
    logic [NumModules-1:0] mask;
    logic                  is_last;
  } change_t;

  // Elapsed counters, reported mask and timeouts, plus the changes still due
  class offline_tracker;
    logic [CountW-1:0]     elapsed [NumModules];
    logic [NumModules-1:0] reported;
    logic [TimeoutW-1:0]   dflt_timeout;
    logic [TimeoutW-1:0]   host_timeout;
    logic [HostIdW-1:0]    host_idx;
    change_t               changes_due[$];
    int unsigned           mismatches;

    function new();
      foreach (elapsed[i]) elapsed[i] = '0;
      reported     = '0;
      dflt_timeout = DefaultTimeoutRst;
      host_timeout = HostTimeoutRst;
      host_idx     = HostModuleRst;
      mismatches   = 0;
    endfunction

    function void set_reg(reg_e r, logic [DataW-1:0] v);
      case (r)
        REG_DEFAULT_TIMEOUT: dflt_timeout = v[TimeoutW-1:0];
        REG_HOST_TIMEOUT:    host_timeout = v[TimeoutW-1:0];
        REG_HOST_MODULE:     host_idx     = v[HostIdW-1:0];
        default: ;
      endcase
    endfunction

    function logic [DataW-1:0] reg_value(reg_e r);
      case (r)
        REG_DEFAULT_TIMEOUT: return DataW'(dflt_timeout);
        REG_HOST_TIMEOUT:    return DataW'(host_timeout);
        default:             return DataW'(host_idx);
      endcase
    endfunction

    // Advance the counters or work out the changes one accepted item causes
    function void take_item(logic [1:0] op, logic [IdxW-1:0] id);
      logic [NumModules-1:0] fresh;
      logic [NumModules-1:0] diff;
      logic [TimeoutW-1:0]   limit;
      change_t               c;
      case (op)
        OP_TICK: begin
          foreach (elapsed[i]) if (elapsed[i] != CountMax) elapsed[i]++;
        end
        OP_BEAT: elapsed[id] = '0;
        OP_SCAN: begin
          fresh = '0;
          for (int i = 0; i < NumModules; i++) begin
            limit    = (i == int'(host_idx)) ? host_timeout : dflt_timeout;
            fresh[i] = elapsed[i] > limit;
          end
          diff = fresh ^ reported;
          // sixteen modules, so every change fits in one scan
          for (int i = 0; i < NumModules; i++) begin
            if (diff[i]) begin
              c.idx       = i[IdxW-1:0];
              c.offline   = fresh[i];
              c.mask      = fresh;
              c.is_last   = (diff >> (i + 1)) == '0;
              reported[i] = fresh[i];
              changes_due.push_back(c);
            end
          end
        end
        default: ;
      endcase
    endfunction

    // Compare one change transfer with the oldest one due
    function void check_change(change_t got);
      change_t want;
      if (changes_due.size() == 0) begin
        $error("change transfer for module %0d with none due", got.idx);
        mismatches++;
        return;
      end
      want = changes_due.pop_front();
      if (got.idx !== want.idx) begin
        $error("changed_module: expected %0d, got %0d", want.idx, got.idx);
        mismatches++;
      end
      if (got.offline !== want.offline) begin
        $error("is_offline: expected %0d, got %0d", want.offline, got.offline);
        mismatches++;
      end
      if (got.mask !== want.mask) begin
        $error("offline_mask: expected %h, got %h", want.mask, got.mask);
        mismatches++;
      end
      if (got.is_last !== want.is_last) begin
        $error("last: expected %0d, got %0d", want.is_last, got.is_last);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic [1:0]            op_i        = OP_TICK;
  logic [IdxW-1:0]       module_id_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [IdxW-1:0]       changed_module_o;
  logic                  is_offline_o;
  logic [NumModules-1:0] offline_mask_o;
  logic                  last_o;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [AddrW-1:0]      paddr       = '0;
  logic [DataW-1:0]      pwdata      = '0;
  logic [DataW-1:0]      prdata;
  logic                  pready;

  offline_tracker tracker;
  bit             calm = 1'b0;
  int unsigned    quiet_cycles = 0;

  multi_module_heartbeat_watchdog dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .module_id_i     (module_id_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .changed_module_o(changed_module_o),
    .is_offline_o    (is_offline_o),
    .offline_mask_o  (offline_mask_o),
    .last_o          (last_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stall the result side at random, except in calm stretches
  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(0, 99) >= 35);
  end

  // Note accepted items and check accepted change transfers
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) tracker.take_item(op_i, module_id_i);
    if (rst_ni && out_valid_o && out_ready_i)
      tracker.check_change({changed_module_o, is_offline_o, offline_mask_o, last_o});
  end

  // Drop the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one item, idling first at random, and hold it until the transfer
  task automatic send_item(logic [1:0] op, logic [IdxW-1:0] id);
    while (!calm && $urandom_range(0, 99) < 35) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    op_i        <= op;
    module_id_i <= id;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_random_item();
    int unsigned     r;
    logic [IdxW-1:0] id;
    r  = $urandom_range(0, 99);
    id = IdxW'($urandom_range(0, NumModules - 1));
    if (r < 45)      send_item(OP_TICK, id);
    else if (r < 80) send_item(OP_BEAT, id);
    else if (r < 95) send_item(OP_SCAN, id);
    else             send_item(OpUnused, id);
  endtask

  // Wait for every change due, then for a scan that reports nothing to finish
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.changes_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic reg_write(reg_e r, logic [DataW-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    tracker.set_reg(r, v);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic reg_read_check(reg_e r);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {r, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== tracker.reg_value(r)) begin
      $error("prdata: expected %h, got %h", tracker.reg_value(r), prdata);
      tracker.mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Set all three registers while idle; upper write bits are noise
  task automatic set_timeouts(logic [TimeoutW-1:0] dflt, logic [TimeoutW-1:0] host,
                              logic [HostIdW-1:0] host_idx);
    drain();
    reg_write(REG_DEFAULT_TIMEOUT, {16'($urandom()), dflt});
    reg_write(REG_HOST_TIMEOUT, {16'($urandom()), host});
    reg_write(REG_HOST_MODULE, {28'($urandom()), host_idx});
    reg_read_check(REG_DEFAULT_TIMEOUT);
    reg_read_check(REG_HOST_TIMEOUT);
    reg_read_check(REG_HOST_MODULE);
  endtask

  initial begin
    logic [TimeoutW-1:0] dflt;
    logic [TimeoutW-1:0] host;
    logic [HostIdW-1:0]  host_idx;
    tracker = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset timeouts: quiet scans, unused op, heartbeats at both ends
    reg_read_check(REG_DEFAULT_TIMEOUT);
    send_item(OP_SCAN, 4'h0);
    send_item(OpUnused, 4'hF);
    send_item(OP_TICK, 4'hA);
    send_item(OP_BEAT, 4'hF);
    send_item(OP_BEAT, 4'h0);
    send_item(OP_SCAN, 4'h5);

    // Zero timeouts: every module drops at once, then a few come back
    set_timeouts(16'd0, 16'd0, 4'd5);
    send_item(OP_TICK, 4'h0);
    send_item(OP_SCAN, 4'h0);
    send_item(OP_BEAT, 4'h3);
    send_item(OP_BEAT, 4'h5);
    send_item(OP_SCAN, 4'h0);
    send_item(OP_BEAT, 4'hA);
    send_item(OP_SCAN, 4'hF);

    // Near-maximum timeouts: every module comes back, then ticks without idling
    set_timeouts(CountMax - 16'd1, CountMax, 4'd15);
    send_item(OP_SCAN, 4'h0);
    calm = 1'b1;
    for (int k = 0; k < BurstTicks; k++) send_item(OP_TICK, 4'h0);
    send_item(OP_SCAN, 4'h0);
    calm = 1'b0;
    send_item(OP_TICK, 4'h0);
    send_item(OP_SCAN, 4'h0);

    // Random phases with small timeouts so modules keep changing state
    for (int p = 0; p < RandPhases; p++) begin
      dflt     = TimeoutW'($urandom_range(0, 40));
      host     = TimeoutW'($urandom_range(0, 60));
      host_idx = HostIdW'($urandom_range(0, NumModules - 1));
      if (p == 1) dflt = CountMax;
      if (p == 2) begin
        host     = '0;
        host_idx = '0;
      end
      if (p == 4) host = CountMax;
      set_timeouts(dflt, host, host_idx);
      calm = (p == 3);
      for (int k = 0; k < PhaseItems; k++) send_random_item();
      send_item(OP_SCAN, IdxW'($urandom_range(0, NumModules - 1)));
      calm = 1'b0;
    end

    drain();
    if (tracker.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
